// ===== rtl/core/iirf_pkg.sv =====
// Shared constants, coefficient tables and control types for the order-10 IIR filter.
package iirf_pkg;

	localparam int FILTER_ORDER   = 10;
	localparam int COEF_FRAC_BITS = 16;
	localparam int TAP_SLOTS      = 17;
	localparam int SLOT_W         = 5;
	localparam int SAMPLE_W       = 32;
	localparam int COEF_W         = 18;
	localparam int PROD_W         = SAMPLE_W + COEF_W;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic clr;
		logic vld;
		logic sub;
	} mac_ctl_t;

	function automatic coef_t ff_coef(input logic [SLOT_W-1:0] slot);
		coef_t c;
		c = '0;
		unique case (slot)
			5'd0:    c = COEF_W'(7104);
			5'd2:    c = -COEF_W'(35513);
			5'd4:    c = COEF_W'(71021);
			5'd6:    c = -COEF_W'(71021);
			5'd8:    c = COEF_W'(35513);
			5'd10:   c = -COEF_W'(7104);
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic coef_t fb_coef(input logic [SLOT_W-1:0] slot);
		coef_t c;
		c = '0;
		unique case (slot)
			5'd0:    c = COEF_W'(65536);
			5'd2:    c = -COEF_W'(64572);
			5'd4:    c = COEF_W'(63818);
			5'd6:    c = -COEF_W'(25323);
			5'd8:    c = COEF_W'(7287);
			5'd10:   c = -COEF_W'(740);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/iirf_hist.sv =====
// Sample history shift line with one selectable read tap.
module iirf_hist #(
	parameter int DEPTH = iirf_pkg::FILTER_ORDER
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  iirf_pkg::sample_t         din,
	input  logic [$clog2(DEPTH)-1:0]  rd_idx,
	output iirf_pkg::sample_t         rd_data
);

	iirf_pkg::sample_t taps_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) taps_q[i] <= '0;
		end else if (shift) begin
			taps_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) taps_q[i] <= taps_q[i-1];
		end
	end

	assign rd_data = (32'(rd_idx) < 32'(DEPTH)) ? taps_q[rd_idx] : '0;

endmodule

// ===== rtl/core/iirf_mac.sv =====
// Shared multiply, Q-format shift and wrapping accumulate/subtract unit.
module iirf_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  iirf_pkg::mac_ctl_t ctl,
	input  iirf_pkg::coef_t    coef,
	input  iirf_pkg::sample_t  sample,
	output iirf_pkg::sample_t  acc
);

	logic signed [iirf_pkg::PROD_W-1:0] prod_s1;
	logic                               vld_s1;
	logic                               sub_s1;
	iirf_pkg::sample_t                  term;
	iirf_pkg::sample_t                  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * $signed(sample);
		sub_s1  <= ctl.sub;
	end

	assign term = prod_s1[iirf_pkg::COEF_FRAC_BITS +: iirf_pkg::SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else if (ctl.clr) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.vld;
			if (vld_s1) begin
				acc_q <= sub_s1 ? acc_q - term : acc_q + term;
			end
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core/iir_filter_order10_q16.sv =====
// Top level of the order-10 direct-form I IIR filter with its tap sequencer.
//
// Usage: samples arrive on the s_axis request channel (tdata = sample_in,
// signed 32 bit) and filtered samples leave on m_axis (tdata = sample_out).
// One multiplier-accumulator serves all taps: the sequencer walks the
// FILTER_ORDER+1 feedforward taps and then the FILTER_ORDER feedback taps,
// one tap per cycle, and then passes ST_DRAIN to drain the product register.
// A sample is accepted in ST_IDLE and passes ST_RUN, ST_DRAIN and ST_DONE;
// sample_out is loaded as ST_DONE ends, and the next sample can be accepted
// only once the sequencer is back in ST_IDLE.
// s_axis_tready is low while a sample is in the tap loop.
// The output register holds one result; a new sample may be accepted while it
// waits, and the finished result of that sample waits in the sequencer until
// the output register is free, so a stalled receiver stalls the input.
// Reset clears both sample histories to zero, empties the output register and
// returns the sequencer to idle; no clearing pass follows reset.
module iir_filter_order10_q16 #(
	parameter int FILTER_ORDER = iirf_pkg::FILTER_ORDER
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] sample_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] sample_out
);

	localparam int TAP_W    = $clog2(2 * FILTER_ORDER + 1);
	localparam int HIDX_W   = $clog2(FILTER_ORDER);
	localparam int LAST_TAP = 2 * FILTER_ORDER;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [TAP_W-1:0]   tap_q;
	iirf_pkg::sample_t  x_q;
	iirf_pkg::sample_t  out_q;
	logic               out_vld_q;

	logic               accept;
	logic               finish;
	logic               is_ff;
	logic [TAP_W-1:0]   hist_off;
	logic [TAP_W-1:0]   slot_full;
	logic [HIDX_W-1:0]  hist_idx;
	iirf_pkg::sample_t  xh_rd;
	iirf_pkg::sample_t  yh_rd;
	iirf_pkg::sample_t  sample_op;
	iirf_pkg::coef_t    coef_op;
	iirf_pkg::sample_t  acc;
	iirf_pkg::mac_ctl_t mac_ctl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign finish        = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

	assign is_ff     = (tap_q <= TAP_W'(FILTER_ORDER));
	assign hist_off  = is_ff ? tap_q - TAP_W'(1) : tap_q - TAP_W'(FILTER_ORDER + 1);
	assign slot_full = is_ff ? tap_q : tap_q - TAP_W'(FILTER_ORDER);
	assign hist_idx  = hist_off[HIDX_W-1:0];

	assign sample_op = (tap_q == '0) ? x_q : (is_ff ? xh_rd : yh_rd);
	assign coef_op   = is_ff ? iirf_pkg::ff_coef(iirf_pkg::SLOT_W'(slot_full))
	                         : iirf_pkg::fb_coef(iirf_pkg::SLOT_W'(slot_full));

	assign mac_ctl.clr = accept;
	assign mac_ctl.vld = (state_q == ST_RUN);
	assign mac_ctl.sub = !is_ff;

	iirf_hist #(.DEPTH(FILTER_ORDER)) u_xhist (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (finish),
		.din     (x_q),
		.rd_idx  (hist_idx),
		.rd_data (xh_rd)
	);

	iirf_hist #(.DEPTH(FILTER_ORDER)) u_yhist (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (finish),
		.din     (acc),
		.rd_idx  (hist_idx),
		.rd_data (yh_rd)
	);

	iirf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_op),
		.sample (sample_op),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (accept) x_q <= s_axis_tdata;
		if (finish) out_q <= acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tap_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= finish || (out_vld_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tap_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_q == TAP_W'(LAST_TAP)) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + TAP_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> tap_q <= TAP_W'(LAST_TAP))
		else $error("tap counter beyond last tap");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("output loaded outside done state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready && state_q == ST_RUN && tap_q == '0)
		else $error("sequencer did not start after request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("pending output dropped");

endmodule

// ===== tb/sv/iirf_response_checker.sv =====
// Output checker for the order-10 IIR filter: predicts each filtered sample and compares it.
module iirf_response_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  iirf_pkg::sample_t       s_axis_tdata,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  iirf_pkg::sample_t       m_axis_tdata,
	output int                      errors,
	output int                      pending
);

	longint ffwd_gain [0:16] = '{7104, 0, -35513, 0, 71021, 0, -71021, 0, 35513, 0, -7104,
		0, 0, 0, 0, 0, 0};
	longint fback_gain [0:16] = '{0, 0, -64572, 0, 63818, 0, -25323, 0, 7287, 0, -740,
		0, 0, 0, 0, 0, 0};

	iirf_pkg::sample_t past_in  [iirf_pkg::FILTER_ORDER];
	iirf_pkg::sample_t past_out [iirf_pkg::FILTER_ORDER];
	iirf_pkg::sample_t expected_out [$];

	function automatic iirf_pkg::sample_t scaled(input longint gain,
		input iirf_pkg::sample_t v);
		longint prod;
		prod = gain * longint'($signed(v));
		prod = prod >>> iirf_pkg::COEF_FRAC_BITS;
		return prod[iirf_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic iirf_pkg::sample_t filter_response(input iirf_pkg::sample_t x);
		iirf_pkg::sample_t acc;
		acc = scaled(ffwd_gain[0], x);
		for (int j = 1; j <= iirf_pkg::FILTER_ORDER && j < iirf_pkg::TAP_SLOTS; j++) begin
			acc = acc + scaled(ffwd_gain[j], past_in[j-1]);
		end
		for (int j = 1; j <= iirf_pkg::FILTER_ORDER && j < iirf_pkg::TAP_SLOTS; j++) begin
			acc = acc - scaled(fback_gain[j], past_out[j-1]);
		end
		for (int j = iirf_pkg::FILTER_ORDER - 1; j > 0; j--) begin
			past_in[j]  = past_in[j-1];
			past_out[j] = past_out[j-1];
		end
		past_in[0]  = x;
		past_out[0] = acc;
		return acc;
	endfunction

	assign pending = expected_out.size();

	always @(posedge clk) begin
		iirf_pkg::sample_t want;
		if (!arst_n) begin
			for (int j = 0; j < iirf_pkg::FILTER_ORDER; j++) begin
				past_in[j]  = '0;
				past_out[j] = '0;
			end
			expected_out.delete();
			errors <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_out.size() == 0) begin
					$display("%0t: unexpected sample_out %0d", $time, $signed(m_axis_tdata));
					errors <= errors + 1;
				end else begin
					want = expected_out.pop_front();
					if (want !== m_axis_tdata) begin
						$display("%0t: sample_out mismatch, expected %0d, got %0d",
							$time, $signed(want), $signed(m_axis_tdata));
						errors <= errors + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_out.push_back(filter_response(s_axis_tdata));
		end
	end

endmodule

// ===== tb/sv/tb_iir_filter_order10_q16.sv =====
// Testbench top for the order-10 IIR filter: sample stimulus, stalls, watchdog and verdict.
module tb_iir_filter_order10_q16;

	localparam int RANDOM_SAMPLES = 1950;
	localparam int IDLE_LIMIT     = 4000;
	localparam int DRAIN_CYCLES   = 30;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	iirf_pkg::sample_t s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	iirf_pkg::sample_t m_axis_tdata;
	int                errors;
	int                pending;
	int                idle_cycles = 0;
	bit                steady = 1'b0;

	iir_filter_order10_q16 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	iirf_response_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= steady || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_sample(input iirf_pkg::sample_t v);
		if (!steady && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic iirf_pkg::sample_t random_sample();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return $urandom;
		else if (pick < 65)
			return iirf_pkg::sample_t'($signed(16'($urandom)));
		else if (pick < 80)
			return iirf_pkg::sample_t'($signed(25'($urandom)));
		else if (pick < 90)
			return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
				: 32'h8000_0000 + $urandom_range(15);
		else
			return iirf_pkg::sample_t'($signed(4'($urandom)));
	endfunction

	initial begin
		iirf_pkg::sample_t edge_samples [$];
		edge_samples = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (edge_samples[i])
			send_sample(edge_samples[i]);
		for (int i = 0; i < RANDOM_SAMPLES; i++) begin
			steady = (i >= 700 && i < 1000);
			send_sample(random_sample());
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
